@@ rtl/pca_pkg.sv @@
// Package for the per-channel pixel arithmetic block.
// Holds the operation codes, register indexes, fixed-point format, pipeline sizes and lane struct.
// Depends on nothing; every module of the block imports it.
package pca_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int NUM_LANES  = 5;
    localparam int DIV_STEPS  = 8;
    localparam int NUM_STAGES = DIV_STEPS + 1;
    localparam int SAT_MAX    = 255;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_MUL = 3'd1;
    localparam logic [2:0] OP_DIV = 3'd2;
    localparam logic [2:0] OP_MOD = 3'd3;
    localparam logic [2:0] OP_MIN = 3'd4;
    localparam logic [2:0] OP_MAX = 3'd5;

    localparam logic [2:0] REG_OP_MODE       = 3'd0;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd1;
    localparam logic [2:0] REG_FACTOR_ZERO   = 3'd2;
    localparam logic [2:0] REG_FACTOR_ONE    = 3'd3;
    localparam logic [2:0] REG_FACTOR_TWO    = 3'd4;
    localparam logic [2:0] REG_FACTOR_THREE  = 3'd5;
    localparam logic [2:0] REG_FACTOR_LAST   = 3'd6;

    typedef struct packed {
        logic [2:0]         op;
        logic               active;
        logic signed [23:0] factor;
    } t_lane_cfg;

endpackage

@@ rtl/pixel_channel_arithmetic.sv @@
// Top level of the per-channel pixel arithmetic block: register port, five lanes, stage control.
// Depends on pca_pkg and pca_lane.
//
//   channel    direction  handshake              payload
//   pixel in   input      i_valid / o_stall      i_sample_zero .. i_sample_four
//   pixel out  output     o_valid / i_stall      o_result_zero .. o_result_four
//   registers  input      psel, penable, pwrite  paddr, pwdata, prdata
//
// An item is accepted every cycle while o_stall is low; its result passes nine stage
// registers: the entry stage and the eight-step divider in every lane.
// Reset clears the stage valid bits and the registers to their defaults.
// An output stall fills empty stages first; o_stall rises only once every stage holds an item.
module pixel_channel_arithmetic #(
    parameter int MAX_CHANNELS  = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_sample_zero,
    input  logic [7:0]  i_sample_one,
    input  logic [7:0]  i_sample_two,
    input  logic [7:0]  i_sample_three,
    input  logic [7:0]  i_sample_four,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_result_zero,
    output logic [7:0]  o_result_one,
    output logic [7:0]  o_result_two,
    output logic [7:0]  o_result_three,
    output logic [7:0]  o_result_four
);
    import pca_pkg::*;

    localparam int L = NUM_STAGES - 1;

    logic [2:0]         r_op_mode;
    logic [2:0]         r_count;
    logic signed [23:0] r_factor [NUM_LANES];
    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] rdy;
    logic [7:0] sample [NUM_LANES];
    logic [7:0] result [NUM_LANES];
    logic       count_ok;
    logic       wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode <= OP_ADD;
            r_count   <= 3'd4;
            for (int i = 0; i < NUM_LANES; i++) r_factor[i] <= 24'sd0;
        end else if (wr) begin
            case (paddr[4:2])
                REG_OP_MODE:       r_op_mode   <= pwdata[2:0];
                REG_CHANNEL_COUNT: r_count     <= pwdata[2:0];
                REG_FACTOR_ZERO:   r_factor[0] <= pwdata[23:0];
                REG_FACTOR_ONE:    r_factor[1] <= pwdata[23:0];
                REG_FACTOR_TWO:    r_factor[2] <= pwdata[23:0];
                REG_FACTOR_THREE:  r_factor[3] <= pwdata[23:0];
                REG_FACTOR_LAST:   r_factor[4] <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_OP_MODE:       prdata = {29'd0, r_op_mode};
            REG_CHANNEL_COUNT: prdata = {29'd0, r_count};
            REG_FACTOR_ZERO:   prdata = {8'd0, r_factor[0]};
            REG_FACTOR_ONE:    prdata = {8'd0, r_factor[1]};
            REG_FACTOR_TWO:    prdata = {8'd0, r_factor[2]};
            REG_FACTOR_THREE:  prdata = {8'd0, r_factor[3]};
            REG_FACTOR_LAST:   prdata = {8'd0, r_factor[4]};
            default:           prdata = 32'd0;
        endcase
    end

    always_comb begin
        rdy[L] = !r_v[L] || !i_stall;
        for (int s = L - 1; s >= 0; s--) rdy[s] = !r_v[s] || rdy[s+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            for (int s = 1; s < NUM_STAGES; s++) begin
                if (rdy[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_v[L];

    assign count_ok = (r_count >= 3'd1) && (32'(r_count) <= MAX_CHANNELS);

    assign sample[0] = i_sample_zero;
    assign sample[1] = i_sample_one;
    assign sample[2] = i_sample_two;
    assign sample[3] = i_sample_three;
    assign sample[4] = i_sample_four;

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        t_lane_cfg cfg;
        assign cfg.op     = r_op_mode;
        assign cfg.active = count_ok && (3'(c) < r_count);
        assign cfg.factor = (3'(c) == r_count - 3'd1) ? r_factor[NUM_LANES-1] : r_factor[c];
        pca_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (rdy),
            .i_cfg    (cfg),
            .i_sample (sample[c]),
            .o_result (result[c])
        );
    end

    assign o_result_zero  = result[0];
    assign o_result_one   = result[1];
    assign o_result_two   = result[2];
    assign o_result_three = result[3];
    assign o_result_four  = result[4];

`ifndef NO_ASSERTIONS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_v))
        else $error("Input stalled while a stage is empty.");
    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |-> !o_stall)
        else $error("Input stalled while the output item is taken.");
`endif

endmodule

@@ rtl/pca_lane.sv @@
// One channel lane: entry stage for add, multiply, min and max, then a pipelined
// restoring divider, one quotient bit per stage, for divide and modulo.
// Depends on pca_pkg.
module pca_lane (
    input  logic                       i_clk,
    input  logic [pca_pkg::NUM_STAGES-1:0] i_en,
    input  pca_pkg::t_lane_cfg         i_cfg,
    input  logic [7:0]                 i_sample,
    output logic [7:0]                 o_result
);
    import pca_pkg::*;

    localparam int L = NUM_STAGES - 1;

    logic [7:0]  r_res [NUM_STAGES];
    logic        r_div [NUM_STAGES];
    logic        r_mod [NUM_STAGES];
    logic [24:0] r_rem [NUM_STAGES];
    logic [7:0]  r_lo  [NUM_STAGES];
    logic [7:0]  r_q   [NUM_STAGES];
    logic [23:0] r_d   [NUM_STAGES];

    logic [7:0]  n_res;
    logic        n_div;
    logic        n_mod;
    logic [24:0] n_rem;
    logic [7:0]  n_lo;
    logic [23:0] n_d;

    always_comb begin
        logic [24:0]        fmag;
        logic [24:0]        kmag;
        logic signed [24:0] k;
        logic signed [25:0] sum;
        logic signed [32:0] prod;
        logic [33:0]        pmag;
        logic [33:0]        pq;
        logic [31:0]        num;
        logic [7:0]         b8;
        fmag = i_cfg.factor[23] ? 25'(-{i_cfg.factor[23], i_cfg.factor})
                                : {1'b0, i_cfg.factor};
        kmag = fmag >> FRACTION_BITS;
        k    = i_cfg.factor[23] ? -$signed(kmag) : $signed(kmag);
        b8   = k[7:0];
        sum  = $signed({18'd0, i_sample}) + 26'(k);
        prod = $signed({1'b0, i_sample}) * i_cfg.factor;
        pmag = {1'b0, prod};
        pq   = pmag >> FRACTION_BITS;
        num  = 32'(i_sample) << FRACTION_BITS;
        n_res = i_sample;
        n_div = 1'b0;
        n_mod = 1'b0;
        n_rem = 25'd0;
        n_lo  = 8'd0;
        n_d   = 24'd0;
        if (i_cfg.active) begin
            case (i_cfg.op)
                OP_ADD: begin
                    if (sum > 26'sd255) n_res = 8'(SAT_MAX);
                    else if (sum < 26'sd0) n_res = 8'd0;
                    else n_res = sum[7:0];
                end
                OP_MUL: begin
                    if (prod[32]) n_res = 8'd0;
                    else if (pq > 34'd255) n_res = 8'(SAT_MAX);
                    else n_res = pq[7:0];
                end
                OP_DIV: begin
                    if (i_cfg.factor == 24'sd0) n_res = 8'(SAT_MAX);
                    else if (i_cfg.factor[23]) n_res = 8'd0;
                    else if (num[31:8] >= i_cfg.factor[23:0]) n_res = 8'(SAT_MAX);
                    else begin
                        n_div = 1'b1;
                        n_rem = {1'b0, num[31:8]};
                        n_lo  = num[7:0];
                        n_d   = i_cfg.factor[23:0];
                    end
                end
                OP_MOD: begin
                    if (kmag == 25'd0) n_res = 8'd0;
                    else begin
                        n_div = 1'b1;
                        n_mod = 1'b1;
                        n_lo  = i_sample;
                        n_d   = kmag[23:0];
                    end
                end
                OP_MIN: n_res = (i_sample < b8) ? i_sample : b8;
                OP_MAX: n_res = (i_sample > b8) ? i_sample : b8;
                default: n_res = i_sample;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_res[0] <= n_res;
            r_div[0] <= n_div;
            r_mod[0] <= n_mod;
            r_rem[0] <= n_rem;
            r_lo[0]  <= n_lo;
            r_q[0]   <= 8'd0;
            r_d[0]   <= n_d;
        end
    end

    for (genvar s = 1; s < NUM_STAGES; s++) begin : g_step
        logic [24:0] rem2;
        logic        ge;
        assign rem2 = {r_rem[s-1][23:0], r_lo[s-1][7]};
        assign ge   = rem2 >= {1'b0, r_d[s-1]};
        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_res[s] <= r_res[s-1];
                r_div[s] <= r_div[s-1];
                r_mod[s] <= r_mod[s-1];
                r_rem[s] <= ge ? rem2 - {1'b0, r_d[s-1]} : rem2;
                r_lo[s]  <= {r_lo[s-1][6:0], 1'b0};
                r_q[s]   <= {r_q[s-1][6:0], ge};
                r_d[s]   <= r_d[s-1];
            end
        end
    end

    assign o_result = r_div[L] ? (r_mod[L] ? r_rem[L][7:0] : r_q[L]) : r_res[L];

endmodule

@@ test/tb_pixel_channel_arithmetic.sv @@
// Testbench for pixel_channel_arithmetic: random and directed pixels under several settings.
// Results are predicted per channel and checked in order; depends on pca_pkg and the RTL.
`timescale 1ns / 1ps

module tb_pixel_channel_arithmetic;
    import pca_pkg::*;

    typedef struct packed {
        logic [7:0] ch4;
        logic [7:0] ch3;
        logic [7:0] ch2;
        logic [7:0] ch1;
        logic [7:0] ch0;
    } t_pixel;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    t_pixel      px_in;
    logic        o_valid;
    logic        i_stall;
    t_pixel      px_out;

    t_pixel      pending_pixels[$];
    t_pixel      expected_pixels[$];
    int          error_count = 0;
    int          sent_count = 0;
    bit          drive_gaps;
    bit          out_gaps;
    int          hold_cycles = 0;
    bit          hold_done = 1'b0;
    int          phase_no = -1;
    bit          in_taken = 1'b0;

    logic [2:0]         cur_op;
    logic [2:0]         cur_count;
    logic signed [23:0] cur_factor[5];

    pixel_channel_arithmetic uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_sample_zero(px_in.ch0), .i_sample_one(px_in.ch1), .i_sample_two(px_in.ch2),
        .i_sample_three(px_in.ch3), .i_sample_four(px_in.ch4),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_zero(px_out.ch0), .o_result_one(px_out.ch1), .o_result_two(px_out.ch2),
        .o_result_three(px_out.ch3), .o_result_four(px_out.ch4)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint trunc_frac(longint x);
        if (x >= 0) begin
            return x >>> 8;
        end
        return -((-x) >>> 8);
    endfunction

    function automatic logic [7:0] clamp_byte(longint x);
        if (x > SAT_MAX) begin
            return 8'(SAT_MAX);
        end
        if (x < 0) begin
            return 8'd0;
        end
        return x[7:0];
    endfunction

    function automatic logic [7:0] adjust_channel(logic [2:0] op, logic [7:0] a,
                                                  logic signed [23:0] f);
        longint av;
        longint fv;
        longint k;
        longint m;
        logic [7:0] b8;
        av = longint'(a);
        fv = longint'(f);
        k = trunc_frac(fv);
        b8 = k[7:0];
        case (op)
            OP_ADD: return clamp_byte(av + k);
            OP_MUL: return clamp_byte(trunc_frac(av * fv));
            OP_DIV: begin
                if (fv == 0) begin
                    return 8'(SAT_MAX);
                end
                return clamp_byte((av * 256) / fv);
            end
            OP_MOD: begin
                m = (k < 0) ? -k : k;
                if (m == 0) begin
                    return 8'd0;
                end
                return 8'(av % m);
            end
            OP_MIN: return (a < b8) ? a : b8;
            OP_MAX: return (a > b8) ? a : b8;
            default: return a;
        endcase
    endfunction

    function automatic t_pixel adjust_pixel(t_pixel p);
        logic [7:0] ins[5];
        logic [7:0] outs[5];
        bit ok;
        ins = '{p.ch0, p.ch1, p.ch2, p.ch3, p.ch4};
        ok = (cur_count >= 1) && (cur_count <= 5);
        for (int c = 0; c < 5; c++) begin
            if (ok && c < cur_count) begin
                outs[c] = adjust_channel(cur_op, ins[c],
                                         (c == cur_count - 1) ? cur_factor[4] : cur_factor[c]);
            end else begin
                outs[c] = ins[c];
            end
        end
        return '{outs[4], outs[3], outs[2], outs[1], outs[0]};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_OP_MODE:       cur_op = value[2:0];
            REG_CHANNEL_COUNT: cur_count = value[2:0];
            REG_FACTOR_ZERO:   cur_factor[0] = value[23:0];
            REG_FACTOR_ONE:    cur_factor[1] = value[23:0];
            REG_FACTOR_TWO:    cur_factor[2] = value[23:0];
            REG_FACTOR_THREE:  cur_factor[3] = value[23:0];
            REG_FACTOR_LAST:   cur_factor[4] = value[23:0];
            default: ;
        endcase
    endtask

    function automatic logic [23:0] random_factor();
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 2048)) - 1024);
            2: return 24'($signed($urandom_range(0, 131072)) - 65536);
            3: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            4: return 24'($urandom_range(0, 1)) ? 24'h0 : 24'($urandom_range(0, 255));
            default: return 24'($signed($urandom_range(0, 8)) - 4) << 8;
        endcase
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel p;
        p = 40'({$urandom, $urandom});
        if ($urandom_range(0, 7) == 0) begin
            p.ch0 = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
        return p;
    endfunction

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || expected_pixels.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pending_pixels.size() != 0 &&
                !(drive_gaps && $urandom_range(0, 99) < 20)) begin
                i_valid <= 1'b1;
                px_in <= pending_pixels.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) begin
            expected_pixels.push_back(adjust_pixel(px_in));
            sent_count++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (phase_no == 3 && !hold_done) begin
            i_stall <= 1'b1;
            hold_cycles <= 59;
            hold_done <= 1'b1;
        end else begin
            i_stall <= out_gaps && ($urandom_range(0, 99) < 20);
        end
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected item", int'(px_out.ch0), 0);
            end else begin
                want = expected_pixels.pop_front();
                if (px_out.ch0 !== want.ch0) report_mismatch("result_zero", px_out.ch0, want.ch0);
                if (px_out.ch1 !== want.ch1) report_mismatch("result_one", px_out.ch1, want.ch1);
                if (px_out.ch2 !== want.ch2) report_mismatch("result_two", px_out.ch2, want.ch2);
                if (px_out.ch3 !== want.ch3) report_mismatch("result_three", px_out.ch3, want.ch3);
                if (px_out.ch4 !== want.ch4) report_mismatch("result_four", px_out.ch4, want.ch4);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [2:0] op;
        logic [2:0] cnt;
        drive_gaps = 1'b0; out_gaps = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cur_op = OP_ADD; cur_count = 3'd4;
        for (int c = 0; c < 5; c++) cur_factor[c] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed pass: reset defaults, then every operation with extreme pixels.
        pending_pixels.push_back('0);
        pending_pixels.push_back('1);
        wait_drained();
        write_reg(REG_CHANNEL_COUNT, 32'd5);
        write_reg(REG_FACTOR_ZERO, 32'h000300);
        write_reg(REG_FACTOR_ONE, 32'hfffd00);
        write_reg(REG_FACTOR_TWO, 32'h000000);
        write_reg(REG_FACTOR_THREE, 32'h7fffff);
        write_reg(REG_FACTOR_LAST, 32'h800000);
        for (int o = 0; o < 8; o++) begin
            write_reg(REG_OP_MODE, 32'(o));
            pending_pixels.push_back('0);
            pending_pixels.push_back('1);
            pending_pixels.push_back(40'h8001_7f_80_05);
            wait_drained();
        end
        write_reg(REG_CHANNEL_COUNT, 32'd0);
        pending_pixels.push_back(40'h12_34_56_78_9a);
        wait_drained();
        write_reg(REG_CHANNEL_COUNT, 32'd7);
        pending_pixels.push_back(40'h9a_78_56_34_12);
        wait_drained();

        // Random phases; the first runs without gaps, one has a long output hold.
        for (int ph = 0; ph < 26; ph++) begin
            op = (ph < 24) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
            cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) :
                  3'($urandom_range(1, 5));
            write_reg(REG_OP_MODE, 32'(op));
            write_reg(REG_CHANNEL_COUNT, 32'(cnt));
            for (int r = 0; r < 5; r++) begin
                write_reg(3'(REG_FACTOR_ZERO + r), 32'(random_factor()));
            end
            drive_gaps = (ph != 0);
            out_gaps = (ph != 0);
            phase_no = ph;
            for (int i = 0; i < 50; i++) pending_pixels.push_back(random_pixel());
            wait_drained();
        end

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pca_pkg.sv
rtl/pca_lane.sv
rtl/pixel_channel_arithmetic.sv
test/tb_pixel_channel_arithmetic.sv
